>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> design/afrs_pkg.sv
// ----------------------------------------------------------------------------
// afrs_pkg
// Types, codes and helpers of the audio ring buffer with rate slip.
// ----------------------------------------------------------------------------
package afrs_pkg;

  localparam int SMP_W  = 16;  // audio sample width
  localparam int REQ_W  = 6;   // request length field width
  localparam int ACT_W  = 2;   // action code width
  localparam int MODE_W = 2;   // expand mode register width
  localparam int ACC_W  = 32;  // slip accumulator width
  localparam int DIV_W  = 17;  // magnitude of step and period after alignment
  localparam int IN_DW  = 56;  // input tdata width, whole bytes

  // Input tdata bit offsets.
  localparam int OFS_SMP  = 0;
  localparam int OFS_REQ  = OFS_SMP + SMP_W;
  localparam int OFS_STEP = OFS_REQ + REQ_W;
  localparam int OFS_PER  = OFS_STEP + SMP_W;

  // Action codes carried in in_tuser.
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GET   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

  // Expand mode codes.
  localparam logic [MODE_W-1:0] MODE_ASIS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HALVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT2,
    ST_RESP,
    ST_GRD,
    ST_GPROC,
    ST_GINS,
    ST_EMRD,
    ST_EMLD
  } state_t;

  // Floor of the mean of two signed samples.
  function automatic logic signed [SMP_W-1:0] half_sum(input logic signed [SMP_W-1:0] a,
                                                       input logic signed [SMP_W-1:0] b);
    logic signed [SMP_W:0] s;
    s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
    return s[SMP_W:1];
  endfunction

endpackage

>>> design/afrs_ram.sv
// ----------------------------------------------------------------------------
// afrs_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module afrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/audio_fifo_rate_slip_top.sv
// ----------------------------------------------------------------------------
// audio_fifo_rate_slip_top
// Audio sample ring buffer with pair halving or interpolated doubling on the
// write side and slip insert/drop rate matching on the read side.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// in_*      input      tvalid/tready      tuser = action, tdata = sample/len/step/period
// out_*     output     tvalid/tready      tdata = sample/fill, tlast = burst end,
//                                         tuser = zero fill/overflow flags
// cfg_*     input      write enable only  expand mode register
//
// A put or flush loads its beat into the output register from ST_RESP, a put in
// doubling mode after a second store in ST_PUT2. A get reads its first sample in
// ST_GRD if any are held, then stored samples one at a time (the single sample
// RAM read port sets the pace) with inserts in ST_GINS, primes the burst buffer
// read in ST_EMRD and loads result beats in ST_EMLD. Reset clears all control
// state. A stalled output holds its beat; the next input beat is still taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_fifo_rate_slip_top
  import afrs_pkg::*;
#(
  parameter int BUF_DEPTH = 4096,
  parameter int MAX_BURST = 32,
  parameter int FW        = $clog2(BUF_DEPTH + 1),
  parameter int OUT_DW    = ((SMP_W + FW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // in_sample, request_len, rate_step, rate_period
  input  logic [ACT_W-1:0]  in_tuser,   // action

  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // out_sample, fill_level
  output logic              out_tlast,  // burst_end
  output logic [1:0]        out_tuser,  // zero_filled, overflow

  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata   // expand_mode
);

  localparam int AW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int LW  = $clog2(MAX_BURST + 1);
  localparam int OBW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

  // Input beat fields.
  logic [ACT_W-1:0]        act;
  logic signed [SMP_W-1:0] smp_in;
  logic [REQ_W-1:0]        req_in;
  logic signed [SMP_W-1:0] step_in;
  logic signed [SMP_W-1:0] per_in;

  assign act     = in_tuser;
  assign smp_in  = in_tdata[OFS_SMP +: SMP_W];
  assign req_in  = in_tdata[OFS_REQ +: REQ_W];
  assign step_in = in_tdata[OFS_STEP +: SMP_W];
  assign per_in  = in_tdata[OFS_PER +: SMP_W];

  // Control and state registers.
  state_t                  state_r, state_nxt;
  logic [MODE_W-1:0]       mode_r, mode_nxt;
  logic [AW-1:0]           widx_r, widx_nxt;
  logic [AW-1:0]           ridx_r, ridx_nxt;
  logic [FW-1:0]           fill_r, fill_nxt;
  logic signed [SMP_W-1:0] prev_r, prev_nxt;
  logic signed [SMP_W-1:0] interp_r, interp_nxt;
  logic                    pend_r, pend_nxt;
  logic signed [SMP_W-1:0] first_r, first_nxt;
  logic signed [SMP_W-1:0] last_r, last_nxt;
  logic [ACC_W-1:0]        slip_r, slip_nxt;
  logic [ACC_W-1:0]        cnt_r, cnt_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic [LW-1:0]           n_r, n_nxt;
  logic [LW-1:0]           k_r, k_nxt;
  logic [DIV_W-1:0]        step_r, step_nxt;
  logic [DIV_W-1:0]        div_r, div_nxt;
  logic                    ins_r, ins_nxt;
  logic signed [SMP_W-1:0] hold_r, hold_nxt;
  logic                    ovf_r, ovf_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0] out_smp_r;
  logic                    out_end_r;
  logic                    out_zf_r;
  logic                    out_ovf_r;
  logic [FW-1:0]           out_fill_r;

  logic                    load;
  logic signed [SMP_W-1:0] ld_smp;
  logic                    ld_end;
  logic                    ld_zf;
  logic                    ld_ovf;

  // Memory ports.
  logic                    sram_we;
  logic [SMP_W-1:0]        sram_wdata;
  logic                    sram_re;
  logic [SMP_W-1:0]        sram_rdata;
  logic                    ob_we;
  logic [OBW-1:0]          ob_waddr;
  logic [SMP_W-1:0]        ob_wdata;
  logic                    ob_re;
  logic [OBW-1:0]          ob_raddr;
  logic [SMP_W-1:0]        ob_rdata;

  // Helpers.
  logic                    full;
  logic                    slot_free;
  logic [AW-1:0]           widx_inc;
  logic [AW-1:0]           ridx_inc;
  logic                    st_en;
  logic signed [SMP_W-1:0] st_val;
  logic signed [SMP_W-1:0] rd_smp;
  logic                    slip_hit;
  logic                    slip_sub;
  logic [ACC_W-1:0]        cnt_upd;
  logic [LW-1:0]           n_inc;
  logic [7:0]              req_ext;
  logic signed [DIV_W-1:0] step_ext;
  logic signed [DIV_W-1:0] per_ext;
  logic signed [DIV_W-1:0] per_al;
  logic [LW-1:0]           n_after;

  assign full      = (fill_r == FW'(BUF_DEPTH));
  assign slot_free = !out_valid_r || out_tready;
  assign widx_inc  = (widx_r == AW'(BUF_DEPTH - 1)) ? '0 : widx_r + AW'(1);
  assign ridx_inc  = (ridx_r == AW'(BUF_DEPTH - 1)) ? '0 : ridx_r + AW'(1);
  assign n_inc     = n_r + LW'(1);
  assign req_ext   = {{(8 - REQ_W){1'b0}}, req_in};
  assign rd_smp    = sram_rdata;

  // Rate step and period aligned so the step is never negative.
  assign step_ext  = step_in[SMP_W-1] ? -{step_in[SMP_W-1], step_in} : {step_in[SMP_W-1], step_in};
  assign per_ext   = {per_in[SMP_W-1], per_in};
  assign per_al    = step_in[SMP_W-1] ? -per_ext : per_ext;

  // Slip test: accumulator, read as signed, above the period magnitude.
  assign slip_hit  = !cnt_r[ACC_W-1] &&
                     (cnt_r[ACC_W-2:0] > {{(ACC_W - 1 - DIV_W){1'b0}}, div_r});
  assign slip_sub  = slip_hit && (!ins_r || (n_inc < len_r));
  assign cnt_upd   = cnt_r - (slip_sub ? {{(ACC_W - DIV_W){1'b0}}, div_r} : '0)
                           + {{(ACC_W - DIV_W){1'b0}}, step_r};

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    widx_nxt   = widx_r;
    ridx_nxt   = ridx_r;
    fill_nxt   = fill_r;
    prev_nxt   = prev_r;
    interp_nxt = interp_r;
    pend_nxt   = pend_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    slip_nxt   = slip_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    step_nxt   = step_r;
    div_nxt    = div_r;
    ins_nxt    = ins_r;
    hold_nxt   = hold_r;
    ovf_nxt    = ovf_r;

    in_tready  = (state_r == ST_IDLE);
    st_en      = 1'b0;
    st_val     = smp_in;
    sram_re    = 1'b0;
    ob_we      = 1'b0;
    ob_waddr   = n_r[OBW-1:0];
    ob_wdata   = rd_smp;
    ob_re      = 1'b0;
    ob_raddr   = k_r[OBW-1:0];
    n_after    = n_r;
    load       = 1'b0;
    ld_smp     = '0;
    ld_end     = 1'b1;
    ld_zf      = 1'b0;
    ld_ovf     = 1'b0;

    if (cfg_we) begin
      mode_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (act)
            ACT_PUT: begin
              prev_nxt  = smp_in;
              hold_nxt  = smp_in;
              ovf_nxt   = 1'b0;
              state_nxt = ST_RESP;
              case (mode_r)
                MODE_HALVE: begin
                  if (!pend_r) begin
                    first_nxt = smp_in;
                    pend_nxt  = 1'b1;
                  end else begin
                    pend_nxt = 1'b0;
                    st_en    = 1'b1;
                    st_val   = half_sum(first_r, smp_in);
                  end
                end
                MODE_DOUBLE: begin
                  st_en      = 1'b1;
                  st_val     = half_sum(interp_r, half_sum(prev_r, smp_in));
                  interp_nxt = st_val;
                  state_nxt  = ST_PUT2;
                end
                default: begin
                  st_en = 1'b1;
                end
              endcase
            end
            ACT_FLUSH: begin
              fill_nxt  = '0;
              widx_nxt  = '0;
              ridx_nxt  = '0;
              ovf_nxt   = 1'b0;
              state_nxt = ST_RESP;
            end
            ACT_GET: begin
              if (req_in != '0) begin
                len_nxt   = (req_ext > 8'(MAX_BURST)) ? LW'(MAX_BURST) : LW'(req_in);
                n_nxt     = '0;
                k_nxt     = '0;
                cnt_nxt   = slip_r;
                step_nxt  = step_ext;
                ins_nxt   = per_al[DIV_W-1];
                div_nxt   = per_al[DIV_W-1] ? -per_al : per_al;
                state_nxt = (fill_r != '0) ? ST_GRD : ST_EMRD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_PUT2: begin
        st_en      = 1'b1;
        st_val     = half_sum(interp_r, hold_r);
        interp_nxt = st_val;
        state_nxt  = ST_RESP;
      end

      ST_RESP: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_ovf    = ovf_r;
          state_nxt = ST_IDLE;
        end
      end

      ST_GRD: begin
        sram_re   = 1'b1;
        ridx_nxt  = ridx_inc;
        fill_nxt  = fill_r - FW'(1);
        state_nxt = ST_GPROC;
      end

      ST_GPROC: begin
        hold_nxt = rd_smp;
        last_nxt = rd_smp;
        cnt_nxt  = cnt_upd;
        if (slip_hit && ins_r && (n_inc < len_r)) begin
          // Interpolated sample first, the read sample next cycle.
          ob_we     = 1'b1;
          ob_wdata  = half_sum(last_r, rd_smp);
          n_nxt     = n_inc;
          state_nxt = ST_GINS;
        end else begin
          if (!(slip_hit && !ins_r)) begin
            ob_we   = 1'b1;
            n_after = n_inc;
          end
          n_nxt = n_after;
          if ((n_after < len_r) && (fill_r != '0)) begin
            sram_re  = 1'b1;
            ridx_nxt = ridx_inc;
            fill_nxt = fill_r - FW'(1);
          end else begin
            slip_nxt  = cnt_upd;
            state_nxt = ST_EMRD;
          end
        end
      end

      ST_GINS: begin
        ob_we    = 1'b1;
        ob_wdata = hold_r;
        n_nxt    = n_inc;
        if ((n_inc < len_r) && (fill_r != '0)) begin
          sram_re   = 1'b1;
          ridx_nxt  = ridx_inc;
          fill_nxt  = fill_r - FW'(1);
          state_nxt = ST_GPROC;
        end else begin
          slip_nxt  = cnt_r;
          state_nxt = ST_EMRD;
        end
      end

      ST_EMRD: begin
        ob_re     = 1'b1;
        state_nxt = ST_EMLD;
      end

      ST_EMLD: begin
        ld_end = (k_r == len_r - LW'(1));
        ld_zf  = !(k_r < n_r);
        ld_smp = (k_r < n_r) ? ob_rdata : '0;
        if (slot_free) begin
          load = 1'b1;
          if (ld_end) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt    = k_r + LW'(1);
            ob_re    = 1'b1;
            ob_raddr = k_nxt[OBW-1:0];
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Common store path for every put state: a full buffer drops the sample.
    sram_we = 1'b0;
    if (st_en) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        sram_we  = 1'b1;
        widx_nxt = widx_inc;
        fill_nxt = fill_r + FW'(1);
      end
    end
    sram_wdata = st_val;

    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_ASIS;
      widx_r      <= '0;
      ridx_r      <= '0;
      fill_r      <= '0;
      prev_r      <= '0;
      interp_r    <= '0;
      pend_r      <= 1'b0;
      first_r     <= '0;
      last_r      <= '0;
      slip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      widx_r      <= widx_nxt;
      ridx_r      <= ridx_nxt;
      fill_r      <= fill_nxt;
      prev_r      <= prev_nxt;
      interp_r    <= interp_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      slip_r      <= slip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-item working registers and the output payload carry no reset.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    len_r  <= len_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    step_r <= step_nxt;
    div_r  <= div_nxt;
    ins_r  <= ins_nxt;
    hold_r <= hold_nxt;
    ovf_r  <= ovf_nxt;
    if (load) begin
      out_smp_r  <= ld_smp;
      out_end_r  <= ld_end;
      out_zf_r   <= ld_zf;
      out_ovf_r  <= ld_ovf;
      out_fill_r <= fill_r;
    end
  end

  // Ring of stored samples.
  afrs_ram #(
    .WIDTH (SMP_W),
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_sample_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (widx_r),
    .wdata (sram_wdata),
    .re    (sram_re),
    .raddr (ridx_r),
    .rdata (sram_rdata)
  );

  // Burst buffer: results of a get are collected here until the final fill
  // level is known, then streamed out.
  afrs_ram #(
    .WIDTH (SMP_W),
    .DEPTH (MAX_BURST),
    .AW    (OBW)
  ) u_burst_ram (
    .clk   (clk),
    .we    (ob_we),
    .waddr (ob_waddr),
    .wdata (ob_wdata),
    .re    (ob_re),
    .raddr (ob_raddr),
    .rdata (ob_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_fill_r, out_smp_r});
  assign out_tlast  = out_end_r;
  assign out_tuser  = {out_ovf_r, out_zf_r};

  `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r <= FW'(BUF_DEPTH), "fill count above depth")
  `ASSERT_IMPLIES(a_no_write_full, clk, rst_n, sram_we, !full, "store into a full buffer")
  `ASSERT_IMPLIES(a_burst_index, clk, rst_n, ob_we, n_r < len_r, "burst buffer overrun")
  `ASSERT_IMPLIES(a_read_before_use, clk, rst_n, state_r == ST_GPROC, $past(sram_re),
                  "sample used without a read")

endmodule

>>> tb/tb_audio_fifo_rate_slip_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_fifo_rate_slip_top
// Drives puts, gets and flushes into the audio ring buffer under all expand
// modes and checks every result beat against a cycle-free model of the ring.
// ----------------------------------------------------------------------------
module tb_audio_fifo_rate_slip_top
  import afrs_pkg::*;
();

  // Widths and sizes of the block under test, as the default parameters give them.
  localparam int RING_DEPTH = 4096;
  localparam int BURST_CAP  = 32;
  localparam int FILL_W     = 13;
  localparam int OUT_W      = 32;

  // Codes that the package leaves unnamed: the fourth action is ignored by the
  // block, and the fourth expand mode stores samples as they come.
  localparam logic [ACT_W-1:0]  ACT_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Cycles the block is given to go idle before a mode write and at the end.
  localparam int SETTLE_CYCLES = 40;
  // Length of the one long receiver hold-off.
  localparam int HOLD_CYCLES = 400;
  // A dropping get may read every stored sample, one per cycle, but the ring
  // never holds more than a few hundred samples in this run, so a healthy
  // block never goes this long without a beat moving on either side, even
  // during the hold-off.
  localparam int WATCHDOG_LIMIT = 4000;
  // Random items, split evenly over the mode phases.
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 15;

  // One input beat, field by field.
  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [SMP_W-1:0] smp;
    logic [REQ_W-1:0]        len;
    logic signed [SMP_W-1:0] step;
    logic signed [SMP_W-1:0] period;
  } audio_cmd_t;

  // One result beat, field by field.
  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    last;
    logic                    zf;
    logic [FILL_W-1:0]       fill;
    logic                    ov;
  } audio_beat_t;

  // A row of the directed table. Where typed is set, every beat of the row
  // carries sample zero and the typed flags and fill level.
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [ACT_W-1:0]        action;
    logic signed [SMP_W-1:0] smp;
    logic [REQ_W-1:0]        len;
    logic signed [SMP_W-1:0] step;
    logic signed [SMP_W-1:0] period;
    logic                    typed;
    logic                    t_zf;
    logic [FILL_W-1:0]       t_fill;
    logic                    t_ov;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;   // in_sample, request_len, rate_step, rate_period
  logic [ACT_W-1:0]  in_tuser;   // action
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // out_sample, fill_level
  logic              out_tlast;  // burst_end
  logic [1:0]        out_tuser;  // zero_filled, overflow
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;  // expand_mode

  // Shared between the sender, the receiver and the checker.
  audio_beat_t audio_beats_owed[$];
  audio_beat_t step_beats[$];
  int          bad_fields;
  int          idle_cycles;
  bit          quiet;
  bit          stall_once;

  // Model state of the ring: what the block should hold after every beat.
  logic signed [SMP_W-1:0] ring_ram [RING_DEPTH];
  int                      wr_ptr;
  int                      rd_ptr;
  int                      held;
  int                      last_put;
  int                      interp_last;
  bit                      pair_waiting;
  int                      pair_head;
  int                      last_read;
  logic [31:0]             slip_acc;
  logic [MODE_W-1:0]       ring_mode;

  // The directed table. It starts on an empty buffer, touches the sample
  // extremes, all actions and modes, saturates the request length, walks
  // insert and drop slips, a zero period and a negative step, changes mode
  // with a half pair pending and ends by reading past a flush.
  plan_row_t directed_plan [25] = '{
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd4,  16'sd0,      16'sd0,
      1'b1, 1'b1, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_PUT,   16'sd32767,  6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd1, 1'b0},
    '{MODE_ASIS,   ACT_PUT,   16'sh8000,   6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd2, 1'b0},
    '{MODE_ASIS,   ACT_PUT,   16'sd0,      6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd3, 1'b0},
    '{MODE_ASIS,   ACT_PUT,   -16'sd1,     6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd4, 1'b0},
    '{MODE_ASIS,   ACT_PUT,   16'sd1234,   6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd5, 1'b0},
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd2,  16'sd0,      16'sd0,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd3,  16'sd100,    -16'sd50,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd40, 16'sh8000,   16'sd32767,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_UNUSED, 16'sd77,    6'd9,  16'sd3,      16'sd3,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd0,  16'sd5,      16'sd5,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_HALVE,  ACT_PUT,   16'sd100,    6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd0, 1'b0},
    '{MODE_HALVE,  ACT_PUT,   -16'sd301,   6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd1, 1'b0},
    '{MODE_HALVE,  ACT_PUT,   16'sd7,      6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd1, 1'b0},
    '{MODE_DOUBLE, ACT_PUT,   16'sh8000,   6'd0,  16'sd0,      16'sd0,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_DOUBLE, ACT_PUT,   16'sd32767,  6'd0,  16'sd0,      16'sd0,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_HALVE,  ACT_PUT,   16'sd5,      6'd0,  16'sd0,      16'sd0,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_SPARE,  ACT_PUT,   16'sd42,     6'd0,  16'sd0,      16'sd0,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd8,  16'sd5,      16'sd0,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_PUT,   16'sd9,      6'd0,  16'sd0,      16'sd0,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_PUT,   16'sd10,     6'd0,  16'sd0,      16'sd0,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd4,  -16'sd7,     16'sd3,
      1'b0, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_FLUSH, 16'sd0,      6'd0,  16'sd0,      16'sd0,
      1'b1, 1'b0, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd1,  16'sd0,      16'sd0,
      1'b1, 1'b1, 13'd0, 1'b0},
    '{MODE_ASIS,   ACT_GET,   16'sd0,      6'd63, 16'sd0,      16'sd0,
      1'b1, 1'b1, 13'd0, 1'b0}
  };

  audio_fifo_rate_slip_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 4 ns clock period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------

  // Floor of the mean; the arithmetic shift rounds toward minus infinity.
  function automatic int mean_floor(input int a, input int b);
    return (a + b) >>> 1;
  endfunction

  // Store one sample unless the ring is full; returns 0 when it was dropped.
  function automatic bit ring_push(input int v);
    if (held >= RING_DEPTH) return 1'b0;
    ring_ram[wr_ptr] = v[SMP_W-1:0];
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    held++;
    return 1'b1;
  endfunction

  function automatic audio_beat_t make_beat(input int smp, input logic last,
                                            input logic zf, input logic ov);
    audio_beat_t b;
    b.smp  = smp[SMP_W-1:0];
    b.last = last;
    b.zf   = zf;
    b.fill = held[FILL_W-1:0];
    b.ov   = ov;
    return b;
  endfunction

  // Advance the ring by one accepted input beat and leave the beats it owes
  // in step_beats.
  task automatic audio_ring_step(input audio_cmd_t cmd);
    int          s;
    int          t;
    int          a;
    int          stp;
    int          per;
    int          mag;
    int          reqn;
    int          n;
    int          rd_val;
    logic [31:0] acc;
    bit          dropped;
    int          vals [BURST_CAP];

    step_beats.delete();
    s = $signed(cmd.smp);
    case (cmd.action)
      ACT_PUT: begin
        dropped = 1'b0;
        if (ring_mode == MODE_HALVE) begin
          // The first of a pair is only held; the second stores their mean.
          if (!pair_waiting) begin
            pair_head = s;
            pair_waiting = 1'b1;
          end else begin
            dropped = !ring_push(mean_floor(pair_head, s));
            pair_waiting = 1'b0;
          end
        end else if (ring_mode == MODE_DOUBLE) begin
          // Two smoothed samples; the second may drop alone at the full mark.
          t = mean_floor(last_put, s);
          a = mean_floor(interp_last, t);
          if (!ring_push(a)) dropped = 1'b1;
          a = mean_floor(a, s);
          if (!ring_push(a)) dropped = 1'b1;
          interp_last = a;
        end else begin
          dropped = !ring_push(s);
        end
        last_put = s;
        step_beats.push_back(make_beat(0, 1'b1, 1'b0, dropped));
      end
      ACT_FLUSH: begin
        held = 0;
        wr_ptr = 0;
        rd_ptr = 0;
        step_beats.push_back(make_beat(0, 1'b1, 1'b0, 1'b0));
      end
      ACT_GET: begin
        if (cmd.len != 0) begin
          reqn = (cmd.len > BURST_CAP) ? BURST_CAP : int'(cmd.len);
          stp = $signed(cmd.step);
          per = $signed(cmd.period);
          // A negative step flips both signs, so the period sign picks
          // insert or drop relative to the step direction.
          if (stp < 0) begin
            stp = -stp;
            per = -per;
          end
          mag = (per < 0) ? -per : per;
          acc = slip_acc;
          n = 0;
          while (n < reqn && held > 0) begin
            rd_val = ring_ram[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            held--;
            if ($signed(acc) > mag) begin
              if (per < 0) begin
                // Insert only when there is room for the sample behind it.
                if (n + 1 < reqn) begin
                  vals[n] = mean_floor(last_read, rd_val);
                  n++;
                  acc = acc - mag;
                end
                vals[n] = rd_val;
                n++;
              end else begin
                acc = acc - mag;
              end
            end else begin
              vals[n] = rd_val;
              n++;
            end
            last_read = rd_val;
            acc = acc + stp;
          end
          slip_acc = acc;
          // Slots not covered by stored samples are zero fill.
          for (int k = 0; k < reqn; k++) begin
            if (k < n) step_beats.push_back(make_beat(vals[k], k == reqn - 1, 1'b0, 1'b0));
            else step_beats.push_back(make_beat(0, k == reqn - 1, 1'b1, 1'b0));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Random item content
  // ---------------------------------------------------------------------------

  // Mostly full-range samples, with the extremes now and then.
  function automatic logic [SMP_W-1:0] rand_sample();
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return 16'($urandom_range(65535));
  endfunction

  // Step and period: small values make slips frequent, full-range values
  // and extremes reach the accumulator wrap and the sign flip.
  function automatic logic [SMP_W-1:0] rand_rate();
    int r;
    int v;

    r = $urandom_range(99);
    if (r < 30) return 16'($urandom_range(65535));
    if (r < 40) begin
      case ($urandom_range(4))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        3: return 16'hffff;
        default: return 16'h0001;
      endcase
    end
    v = int'($urandom_range(400)) - 200;
    return v[SMP_W-1:0];
  endfunction

  // Puts outnumber gets so the ring holds data; flushes stay rare so that
  // bursts read deep into the stored stream.
  function automatic audio_cmd_t random_cmd();
    audio_cmd_t c;
    int         r;
    int         rl;

    r = $urandom_range(99);
    rl = $urandom_range(99);
    c.smp = rand_sample();
    c.step = rand_rate();
    c.period = rand_rate();
    if (rl < 5) c.len = '0;
    else if (rl < 15) c.len = 6'($urandom_range(63, 33));
    else c.len = 6'($urandom_range(32, 1));
    if (r < 55) c.action = ACT_PUT;
    else if (r < 93) c.action = ACT_GET;
    else if (r < 97) c.action = ACT_FLUSH;
    else c.action = ACT_UNUSED;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one beat, wait for it to be taken, book the beats it owes and then
  // maybe leave a gap. tvalid stays high straight into the next beat when no
  // gap is taken.
  task automatic send_item(input audio_cmd_t cmd, input bit typed, input logic t_zf,
                           input logic [FILL_W-1:0] t_fill, input logic t_ov);
    audio_beat_t b;

    in_tvalid <= 1'b1;
    in_tuser  <= cmd.action;
    in_tdata  <= {2'b00, cmd.period, cmd.step, cmd.len, cmd.smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    audio_ring_step(cmd);
    foreach (step_beats[k]) begin
      b = step_beats[k];
      if (typed) begin
        b.smp  = '0;
        b.zf   = t_zf;
        b.fill = t_fill;
        b.ov   = t_ov;
      end
      audio_beats_owed.push_back(b);
    end
    if (!quiet && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // The mode register is only written with the block drained. Items that owe
  // no beat may still be in flight when the queue runs dry, hence the settle.
  task automatic write_mode(input logic [MODE_W-1:0] m);
    in_tvalid <= 1'b0;
    while (audio_beats_owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ring_mode = m;
  endtask

  task automatic put_random();
    audio_cmd_t c;

    c = random_cmd();
    c.action = ACT_PUT;
    send_item(c, 1'b0, 1'b0, '0, 1'b0);
  endtask

  initial begin : stimulus
    audio_cmd_t        c;
    plan_row_t         row;
    logic [MODE_W-1:0] m;

    // Every input known from time zero; reset held low, then released.
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = ACT_PUT;
    cfg_we       = 1'b0;
    cfg_wdata    = MODE_ASIS;
    quiet        = 1'b0;
    stall_once   = 1'b0;
    bad_fields   = 0;
    wr_ptr       = 0;
    rd_ptr       = 0;
    held         = 0;
    last_put     = 0;
    interp_last  = 0;
    pair_waiting = 1'b0;
    pair_head    = 0;
    last_read    = 0;
    slip_acc     = '0;
    ring_mode    = MODE_ASIS;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; a row in another mode first drains and rewrites it.
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.mode != ring_mode) write_mode(row.mode);
      c.action = row.action;
      c.smp    = row.smp;
      c.len    = row.len;
      c.step   = row.step;
      c.period = row.period;
      send_item(c, row.typed, row.t_zf, row.t_fill, row.t_ov);
    end

    // A handful of plain samples, drained with a dropping and an inserting
    // slip, then a flush.
    write_mode(MODE_ASIS);
    repeat (8) put_random();
    c = random_cmd();
    c.action = ACT_GET;
    c.len    = 6'd32;
    c.step   = 16'sd2;
    c.period = 16'sd1;
    repeat (3) send_item(c, 1'b0, 1'b0, '0, 1'b0);
    c.period = -16'sd1;
    send_item(c, 1'b0, 1'b0, '0, 1'b0);
    c.action = ACT_FLUSH;
    send_item(c, 1'b0, 1'b0, '0, 1'b0);

    // Random phases, one mode each. The second phase holds the
    // receiver off for a long stretch; the last one runs with no gaps.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: m = MODE_HALVE;
        1: m = MODE_SPARE;
        2: m = MODE_DOUBLE;
        3: m = MODE_ASIS;
        default: m = MODE_DOUBLE;
      endcase
      write_mode(m);
      quiet = (p == PHASES - 1);
      if (p == 1) stall_once = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        c = random_cmd();
        send_item(c, 1'b0, 1'b0, '0, 1'b0);
      end
    end

    // Drain, then give the block time to show any beat it should not send.
    in_tvalid <= 1'b0;
    while (audio_beats_owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_fields == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------

  // tready drops about a quarter of the time, except in the quiet phase.
  // Once, on request, it stays low for a long stretch so the block backs up
  // into its input.
  initial begin : sink_side
    int held_off;

    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_once) begin
        stall_once = 1'b0;
        out_tready <= 1'b0;
        held_off = 0;
        while (held_off < HOLD_CYCLES) begin
          @(posedge clk);
          held_off++;
        end
      end
      out_tready <= quiet || ($urandom_range(99) >= 24);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      bad_fields++;
    end
  endtask

  // Each beat taken from the block is matched against the oldest one owed.
  always @(posedge clk) begin
    audio_beat_t want;

    if (rst_n && out_tvalid && out_tready) begin
      if (audio_beats_owed.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual sample %0d last %0b",
                 $time, $signed(out_tdata[SMP_W-1:0]), out_tlast);
        bad_fields++;
      end else begin
        want = audio_beats_owed.pop_front();
        check_field("out_sample", int'($signed(want.smp)),
                    int'($signed(out_tdata[SMP_W-1:0])));
        check_field("burst_end", int'(want.last), int'(out_tlast));
        check_field("zero_filled", int'(want.zf), int'(out_tuser[0]));
        check_field("fill_level", int'(want.fill), int'(out_tdata[SMP_W +: FILL_W]));
        check_field("overflow", int'(want.ov), int'(out_tuser[1]));
      end
    end
  end

  // Watchdog: too long with no beat moving on either side means a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

>>> audio_fifo_rate_slip_top.f
+incdir+design
design/afrs_pkg.sv
design/afrs_ram.sv
design/audio_fifo_rate_slip_top.sv
tb/tb_audio_fifo_rate_slip_top.sv
